### rtl/assert_macros.svh
// Assertion helpers; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OLE_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OLE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ole_pkg.sv
package ole_pkg;

  localparam int VAL_W    = 32;
  localparam int OCC_W    = 7;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_SEARCH   = 3'd2,
    MODE_DELETE   = 3'd3,
    MODE_READ_FWD = 3'd4,
    MODE_READ_BWD = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_VALUE = 2'd0,
    SRC_RDATA = 2'd1,
    SRC_ZERO  = 2'd2
  } out_src_t;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_SHIFT    = 3'd3,
    OP_DROP     = 3'd4
  } dp_op_t;

  typedef struct packed {
    logic             latch;
    logic             rd_en;
    logic [OCC_W-1:0] rd_idx;
    dp_op_t           op;
    logic [OCC_W-1:0] wr_idx;
    logic             out_load;
    out_src_t         out_src;
    logic             out_found;
    status_t          out_status;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [OCC_W-1:0] occ;
    logic             full;
    logic             match;
    logic             out_free;
  } dp_sts_t;

endpackage

### rtl/ordered_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit values, kept as a ring in one
// entry memory with a head pointer, so inserts at either end take a single
// write. Search, delete and readout walk the entries through the memory's
// one read port, one entry per cycle while results are taken without stall
// (a delete scans to the match, then moves the later entries one place
// toward the head). One request is worked on at a time; a new request is
// taken as soon as the previous one has handed its last result to the output
// register, even if that result still waits there. Requests with modes 6 and
// 7 are dropped with no result. No clearing pass is needed after reset.
module ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ole_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [ole_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ole_pkg::VAL_W-1:0]  out_entry,
  output logic                              out_found,
  output logic [ole_pkg::STATUS_W-1:0]      out_status,
  output logic [ole_pkg::OCC_W-1:0]         out_entries,
  output logic                              out_last
);

  ole_pkg::dp_cmd_t cmd;
  ole_pkg::dp_sts_t sts;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  ole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_entry   (out_entry),
    .out_found   (out_found),
    .out_status  (out_status),
    .out_entries (out_entries),
    .out_last    (out_last)
  );

endmodule

### rtl/ole_dp.sv
module ole_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ole_pkg::dp_cmd_t                  cmd,
  output ole_pkg::dp_sts_t                  sts,
  input  logic signed [ole_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ole_pkg::VAL_W-1:0]  out_entry,
  output logic                              out_found,
  output logic [ole_pkg::STATUS_W-1:0]      out_status,
  output logic [ole_pkg::OCC_W-1:0]         out_entries,
  output logic                              out_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW:0]   CAP_EXT   = (IW+1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

  logic [ole_pkg::VAL_W-1:0] mem [CAPACITY];

  logic [IW-1:0]                head_r;
  logic [ole_pkg::OCC_W-1:0]    occ_r;
  logic [ole_pkg::VAL_W-1:0]    value_r;
  logic [ole_pkg::VAL_W-1:0]    rd_data_r;
  logic                         out_valid_r;
  logic [ole_pkg::VAL_W-1:0]    out_entry_r;
  logic                         out_found_r;
  ole_pkg::status_t             out_status_r;
  logic [ole_pkg::OCC_W-1:0]    out_entries_r;
  logic                         out_last_r;

  logic [IW-1:0]             head_dec;
  logic [IW-1:0]             rd_addr;
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic [ole_pkg::VAL_W-1:0] wr_data;
  logic [ole_pkg::VAL_W-1:0] out_entry_nxt;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= CAP_EXT) begin
      s = s - CAP_EXT;
    end
    return s[IW-1:0];
  endfunction

  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign rd_addr  = phys(head_r, cmd.rd_idx[IW-1:0]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head_dec;
    wr_data = value_r;
    case (cmd.op)
      ole_pkg::OP_INS_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = head_dec;
      end
      ole_pkg::OP_INS_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, occ_r[IW-1:0]);
      end
      ole_pkg::OP_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, cmd.wr_idx[IW-1:0]);
        wr_data = rd_data_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.out_src)
      ole_pkg::SRC_RDATA: out_entry_nxt = rd_data_r;
      ole_pkg::SRC_ZERO:  out_entry_nxt = '0;
      default:            out_entry_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.latch) begin
      value_r <= in_value;
    end
    if (cmd.out_load) begin
      out_entry_r   <= out_entry_nxt;
      out_found_r   <= cmd.out_found;
      out_status_r  <= cmd.out_status;
      out_entries_r <= occ_r;
      out_last_r    <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        ole_pkg::OP_INS_HEAD: begin
          head_r <= head_dec;
          occ_r  <= occ_r + 1'b1;
        end
        ole_pkg::OP_INS_TAIL: begin
          occ_r <= occ_r + 1'b1;
        end
        ole_pkg::OP_DROP: begin
          occ_r <= occ_r - 1'b1;
        end
        default: begin
          occ_r <= occ_r;
        end
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.occ      = occ_r;
  assign sts.full     = (occ_r == ole_pkg::OCC_W'(CAPACITY));
  assign sts.match    = (rd_data_r == value_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_entry   = out_entry_r;
  assign out_found   = out_found_r;
  assign out_status  = out_status_r;
  assign out_entries = out_entries_r;
  assign out_last    = out_last_r;

endmodule

### rtl/ole_ctrl.sv
module ole_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ole_pkg::MODE_W-1:0]     in_mode,
  input  ole_pkg::dp_sts_t               sts,
  output ole_pkg::dp_cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  ole_pkg::mode_t            mode_r, mode_nxt;
  logic [ole_pkg::OCC_W-1:0] idx_r, idx_nxt;
  logic [ole_pkg::OCC_W-1:0] pidx_r, pidx_nxt;
  logic                      pend_r, pend_nxt;
  logic                      found_r, found_nxt;
  ole_pkg::status_t          status_r, status_nxt;
  ole_pkg::out_src_t         src_r, src_nxt;

  logic                      more;
  logic                      consume;
  logic                      issue;
  logic                      is_last;
  logic [ole_pkg::OCC_W-1:0] occ_m1;

  assign in_ready = (state_r == S_IDLE);
  assign more     = (idx_r < sts.occ);
  assign occ_m1   = ole_pkg::OCC_W'(sts.occ - 1'b1);
  assign is_last  = (pidx_r == occ_m1);
  assign consume  = pend_r && sts.out_free;
  assign issue    = more && (!pend_r || sts.out_free);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    src_nxt    = src_r;
    cmd            = '0;
    cmd.op         = ole_pkg::OP_NONE;
    cmd.out_src    = ole_pkg::SRC_VALUE;
    cmd.out_status = ole_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          mode_nxt  = ole_pkg::mode_t'(in_mode);
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          src_nxt   = ole_pkg::SRC_VALUE;
          case (ole_pkg::mode_t'(in_mode))
            ole_pkg::MODE_INS_HEAD, ole_pkg::MODE_INS_TAIL: state_nxt = S_INS;
            ole_pkg::MODE_SEARCH, ole_pkg::MODE_DELETE:     state_nxt = S_SCAN;
            ole_pkg::MODE_READ_FWD, ole_pkg::MODE_READ_BWD: state_nxt = S_READ;
            default:                                        state_nxt = S_IDLE;
          endcase
        end
      end

      S_INS: begin
        if (sts.full) begin
          status_nxt = ole_pkg::ST_FULL;
        end else begin
          status_nxt = ole_pkg::ST_OK;
          cmd.op = (mode_r == ole_pkg::MODE_INS_HEAD) ? ole_pkg::OP_INS_HEAD
                                                      : ole_pkg::OP_INS_TAIL;
        end
        state_nxt = S_EMIT;
      end

      S_SCAN: begin
        if (pend_r && sts.match) begin
          if (mode_r == ole_pkg::MODE_SEARCH) begin
            found_nxt  = 1'b1;
            status_nxt = ole_pkg::ST_OK;
            state_nxt  = S_EMIT;
          end else begin
            idx_nxt   = pidx_r + 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end
        end else if (more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = idx_r;
          pend_nxt   = 1'b1;
          pidx_nxt   = idx_r;
          idx_nxt    = idx_r + 1'b1;
        end else begin
          found_nxt  = 1'b0;
          status_nxt = ole_pkg::ST_NOT_FOUND;
          state_nxt  = S_EMIT;
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          cmd.op     = ole_pkg::OP_SHIFT;
          cmd.wr_idx = pidx_r - 1'b1;
        end
        if (more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = idx_r;
          pend_nxt   = 1'b1;
          pidx_nxt   = idx_r;
          idx_nxt    = idx_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          cmd.op     = ole_pkg::OP_DROP;
          found_nxt  = 1'b1;
          status_nxt = ole_pkg::ST_OK;
          state_nxt  = S_EMIT;
        end
      end

      S_READ: begin
        if (sts.occ == '0) begin
          found_nxt  = 1'b0;
          status_nxt = ole_pkg::ST_EMPTY;
          src_nxt    = ole_pkg::SRC_ZERO;
          state_nxt  = S_EMIT;
        end else begin
          if (consume) begin
            cmd.out_load   = 1'b1;
            cmd.out_src    = ole_pkg::SRC_RDATA;
            cmd.out_status = ole_pkg::ST_OK;
            cmd.out_last   = is_last;
          end
          if (issue) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = (mode_r == ole_pkg::MODE_READ_FWD) ? idx_r
                         : ole_pkg::OCC_W'(occ_m1 - idx_r);
            pend_nxt   = 1'b1;
            pidx_nxt   = idx_r;
            idx_nxt    = idx_r + 1'b1;
          end else if (consume) begin
            pend_nxt = 1'b0;
          end
          if (consume && is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_src    = src_r;
          cmd.out_found  = found_r;
          cmd.out_status = status_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= ole_pkg::MODE_INS_HEAD;
      idx_r    <= '0;
      pidx_r   <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
      status_r <= ole_pkg::ST_OK;
      src_r    <= ole_pkg::SRC_VALUE;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      pidx_r   <= pidx_nxt;
      pend_r   <= pend_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
      src_r    <= src_nxt;
    end
  end

endmodule

### rtl/ole_checker.sv
`include "assert_macros.svh"

module ole_checker #(
  parameter int CAPACITY = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ole_pkg::VAL_W-1:0]  out_entry,
  input logic                              out_found,
  input logic [ole_pkg::STATUS_W-1:0]      out_status,
  input logic [ole_pkg::OCC_W-1:0]         out_entries,
  input logic                              out_last
);

  `OLE_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_entry) && $stable(out_status) && $stable(out_entries) && $stable(out_last), "result changed while stalled")

  `OLE_CHECK(a_count_range, out_valid, out_entries <= ole_pkg::OCC_W'(CAPACITY), "entry count above capacity")

  `OLE_CHECK(a_full_drop, out_valid && out_status == ole_pkg::ST_FULL, out_entries == ole_pkg::OCC_W'(CAPACITY) && out_last && !out_found, "full status with room left")

  `OLE_CHECK(a_found_ok, out_valid && out_found, out_status == ole_pkg::ST_OK && out_last, "match reported with bad status")

  `OLE_CHECK(a_empty_read, out_valid && out_status == ole_pkg::ST_EMPTY, out_entries == '0 && out_entry == '0 && out_last && !out_found, "empty status on non-empty list")

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);
